[hw/rtl/csfb_pkg.sv]
// Shared types, constants and segment tables for the clock frame builder.
`timescale 1ns / 1ps

package csfb_pkg;

    // Frame geometry and digit split sequence.
    localparam int unsigned FRAME_BYTES = 14;
    localparam int unsigned SPLIT_STEPS = 9;
    localparam logic [3:0]  LAST_ADDR   = 4'(FRAME_BYTES - 1);
    localparam logic [3:0]  LAST_STEP   = 4'(SPLIT_STEPS - 1);

    // Split steps that start a new field; the others work on the kept quotient.
    localparam logic [3:0] STEP_YEAR   = 4'd0;
    localparam logic [3:0] STEP_YEAR_T = 4'd1;
    localparam logic [3:0] STEP_YEAR_H = 4'd2;
    localparam logic [3:0] STEP_SEC    = 4'd3;
    localparam logic [3:0] STEP_SEC_T  = 4'd4;
    localparam logic [3:0] STEP_MIN    = 4'd5;
    localparam logic [3:0] STEP_MIN_T  = 4'd6;
    localparam logic [3:0] STEP_HOUR   = 4'd7;
    localparam logic [3:0] STEP_HOUR_T = 4'd8;

    // Frame addresses that carry a status lamp in bit 1.
    localparam logic [3:0] ADDR_MINUTE_LAMP  = 4'd1;
    localparam logic [3:0] ADDR_HOUR_LAMP    = 4'd3;
    localparam logic [3:0] ADDR_NETWORK_LAMP = 4'd7;
    localparam logic [3:0] ADDR_ENABLED_LAMP = 4'd9;
    localparam logic [3:0] ADDR_NTP_LAMP     = 4'd11;

    // Years below this value have a blank hundreds digit when suppression is on.
    localparam logic [13:0] YEAR_FULL = 14'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       split;
        logic [3:0] step;
        logic       load;
        logic [3:0] index;
    } t_dp_cmd;

    // Segment pattern of a decimal digit, bit s is segment s (A is bit 0).
    function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
        logic [6:0] pat;
        case (digit)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

    // Segment served by an even/odd address pair, from the pair number.
    function automatic logic [2:0] seg_of_pair(input logic [2:0] pair);
        logic [2:0] seg;
        case (pair)
            3'd0:    seg = 3'd3;  // D
            3'd1:    seg = 3'd2;  // C
            3'd2:    seg = 3'd1;  // B
            3'd3:    seg = 3'd0;  // A
            3'd4:    seg = 3'd5;  // F
            3'd5:    seg = 3'd6;  // G
            3'd6:    seg = 3'd4;  // E
            default: seg = 3'd0;
        endcase
        return seg;
    endfunction

    // Digit slot written by each split step; slot 8 is the year hundreds.
    function automatic logic [3:0] slot_of_step(input logic [3:0] step);
        logic [3:0] slot;
        case (step)
            STEP_YEAR:   slot = 4'd6;
            STEP_YEAR_T: slot = 4'd7;
            STEP_YEAR_H: slot = 4'd8;
            STEP_SEC:    slot = 4'd0;
            STEP_SEC_T:  slot = 4'd1;
            STEP_MIN:    slot = 4'd2;
            STEP_MIN_T:  slot = 4'd3;
            STEP_HOUR:   slot = 4'd4;
            STEP_HOUR_T: slot = 4'd5;
            default:     slot = 4'd0;
        endcase
        return slot;
    endfunction

endpackage

[hw/rtl/csfb_datapath.sv]
// Datapath: field capture, shared divide-by-ten unit, digit store and byte builder.
`timescale 1ns / 1ps

module csfb_datapath import csfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [13:0] i_year_value,
    input  logic [6:0]  i_hour_value,
    input  logic [6:0]  i_minute_value,
    input  logic [6:0]  i_second_value,
    input  logic        i_minute_lamp,
    input  logic        i_hour_lamp,
    input  logic        i_ntp_lamp,
    input  logic        i_enabled_lamp,
    input  logic        i_network_lamp,
    input  logic        i_cfg_write,
    input  logic        i_cfg_suppress_leading,
    output logic [3:0]  o_frame_address,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_last
);

    logic        r_suppress;
    logic [13:0] r_year;
    logic [6:0]  r_hour;
    logic [6:0]  r_minute;
    logic [6:0]  r_second;
    logic [4:0]  r_lamps;
    logic        r_blank;
    logic [10:0] r_quot;
    logic [3:0]  r_digit [0:8];
    logic [3:0]  r_addr;
    logic [7:0]  r_byte;
    logic        r_last;

    logic [13:0] w_operand;
    logic [26:0] w_prod;
    logic [10:0] w_q_est;
    logic [13:0] w_qx10;
    logic [13:0] w_r_est;
    logic [10:0] w_q;
    logic [3:0]  w_r;
    logic [2:0]  w_seg;
    logic [6:0]  w_pat [0:8];
    logic [7:0]  w_even;
    logic        w_hund;
    logic        w_lamp;
    logic [7:0]  w_byte;

    // The suppression register is the only configuration state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suppress <= 1'b0;
        end else if (i_cfg_write) begin
            r_suppress <= i_cfg_suppress_leading;
        end
    end

    // Capture the request fields; the hundreds blank is decided here.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_year   <= i_year_value;
            r_hour   <= i_hour_value;
            r_minute <= i_minute_value;
            r_second <= i_second_value;
            r_lamps  <= {i_ntp_lamp, i_enabled_lamp, i_network_lamp,
                         i_hour_lamp, i_minute_lamp};
            r_blank  <= r_suppress && (i_year_value < YEAR_FULL);
        end
    end

    // Operand for the current split step.
    always_comb begin
        case (i_cmd.step)
            STEP_YEAR: w_operand = r_year;
            STEP_SEC:  w_operand = 14'(r_second);
            STEP_MIN:  w_operand = 14'(r_minute);
            STEP_HOUR: w_operand = 14'(r_hour);
            default:   w_operand = 14'(r_quot);
        endcase
    end

    // Divide by ten: the reciprocal estimate is low by at most one, so one
    // compare and subtract fixes quotient and remainder.
    always_comb begin
        w_prod  = 27'(w_operand) * 27'd6553;
        w_q_est = w_prod[26:16];
        w_qx10  = 14'({w_q_est, 3'b000}) + 14'({w_q_est, 1'b0});
        w_r_est = w_operand - w_qx10;
        if (w_r_est >= 14'd10) begin
            w_q = w_q_est + 11'd1;
            w_r = 4'(w_r_est - 14'd10);
        end else begin
            w_q = w_q_est;
            w_r = w_r_est[3:0];
        end
    end

    // Keep the quotient for the next step and store the digit in its slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.split) begin
            r_quot <= w_q;
            r_digit[slot_of_step(i_cmd.step)] <= w_r;
        end
    end

    // Build the frame byte for the requested address from the stored digits.
    always_comb begin
        w_seg = seg_of_pair(i_cmd.index[3:1]);
        for (int d = 0; d < 9; d++) begin
            w_pat[d] = seg_pattern(r_digit[d]);
        end
        for (int d = 0; d < 8; d++) begin
            w_even[d] = w_pat[d][w_seg];
        end
        w_hund = r_blank ? 1'b0 : w_pat[8][w_seg];
        case (i_cmd.index)
            ADDR_MINUTE_LAMP:  w_lamp = r_lamps[0];
            ADDR_HOUR_LAMP:    w_lamp = r_lamps[1];
            ADDR_NETWORK_LAMP: w_lamp = r_lamps[2];
            ADDR_ENABLED_LAMP: w_lamp = r_lamps[3];
            ADDR_NTP_LAMP:     w_lamp = r_lamps[4];
            default:           w_lamp = 1'b0;
        endcase
        w_byte = i_cmd.index[0] ? {6'b000000, w_lamp, w_hund} : w_even;
    end

    // Output register holds the byte until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_cmd.index;
            r_byte <= w_byte;
            r_last <= (i_cmd.index == LAST_ADDR);
        end
    end

    assign o_frame_address = r_addr;
    assign o_frame_byte    = r_byte;
    assign o_frame_last    = r_last;

endmodule

[hw/rtl/csfb_controller.sv]
// Controller: sequences capture, digit split and frame emission.
`timescale 1ns / 1ps

module csfb_controller import csfb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;
    logic [3:0] r_index, n_index;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 4'd0;
            r_index     <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_index     <= n_index;
            r_out_valid <= n_out_valid;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_index     = r_index;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        o_cmd.index = r_index;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_step        = 4'd0;
                    n_state       = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                o_cmd.split = 1'b1;
                n_step      = r_step + 4'd1;
                if (r_step == LAST_STEP) begin
                    n_index = 4'd0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_index     = r_index + 4'd1;
                    if (r_index == LAST_ADDR) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // An accepted request always starts the split at its first step.
    a_start_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_SPLIT && r_step == 4'd0))
        else $error("split did not start after an accepted request");

    // Loading the last frame byte returns the block to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && r_index == LAST_ADDR) |=> (r_state == ST_IDLE))
        else $error("controller did not return to idle after the last byte");

    // Emission index stays inside the frame.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_index <= LAST_ADDR))
        else $error("emission index beyond the frame");

    // Split step stays inside the digit sequence.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SPLIT) |-> (r_step <= LAST_STEP))
        else $error("split step beyond the digit sequence");
`endif

endmodule

[hw/rtl/clock_seven_segment_frame_builder_core.sv]
// Top level of the clock seven-segment frame builder.
//
// Channel   Direction  Handshake                     Carries
// input     in         i_in_valid / o_in_ready       year, hour, minute, second, lamps
// output    out        o_out_valid / i_out_ready     frame_address, frame_byte, frame_last
// config    in         i_cfg_valid / o_cfg_ready     suppress_leading
//
// Each request is captured, split into digits in nine steps through the single
// shared divide-by-ten unit, and its fourteen frame bytes are then emitted from
// the output register, one per cycle while the consumer is ready.
// Reset clears the controller, the output valid and the suppression register.
// A stalled consumer holds the current byte and pauses emission; the next
// request is taken once the last byte of the frame is in the output register.
`timescale 1ns / 1ps

module clock_seven_segment_frame_builder_core import csfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [13:0] i_year_value,
    input  logic [6:0]  i_hour_value,
    input  logic [6:0]  i_minute_value,
    input  logic [6:0]  i_second_value,
    input  logic        i_minute_lamp,
    input  logic        i_hour_lamp,
    input  logic        i_ntp_lamp,
    input  logic        i_enabled_lamp,
    input  logic        i_network_lamp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_frame_address,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_suppress_leading
);

    t_dp_cmd w_cmd;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    csfb_controller u_controller (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    csfb_datapath u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (w_cmd),
        .i_year_value           (i_year_value),
        .i_hour_value           (i_hour_value),
        .i_minute_value         (i_minute_value),
        .i_second_value         (i_second_value),
        .i_minute_lamp          (i_minute_lamp),
        .i_hour_lamp            (i_hour_lamp),
        .i_ntp_lamp             (i_ntp_lamp),
        .i_enabled_lamp         (i_enabled_lamp),
        .i_network_lamp         (i_network_lamp),
        .i_cfg_write            (i_cfg_valid && o_cfg_ready),
        .i_cfg_suppress_leading (i_cfg_suppress_leading),
        .o_frame_address        (o_frame_address),
        .o_frame_byte           (o_frame_byte),
        .o_frame_last           (o_frame_last)
    );

endmodule

[tb/csfb_frame_checker.sv]
// Checker that predicts and compares every frame byte of the clock frame builder.
`timescale 1ns / 1ps

module csfb_frame_checker import csfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [13:0] i_year_value,
    input  logic [6:0]  i_hour_value,
    input  logic [6:0]  i_minute_value,
    input  logic [6:0]  i_second_value,
    input  logic        i_minute_lamp,
    input  logic        i_hour_lamp,
    input  logic        i_ntp_lamp,
    input  logic        i_enabled_lamp,
    input  logic        i_network_lamp,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_frame_address,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_suppress_leading,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_updates,
    output int          o_bytes_checked
);

    // Segment masks of the digits 0 to 9, segment A in bit 0.
    localparam logic [9:0][6:0] DIGIT_SEGMENTS = {
        7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    // Even frame address of each segment, A in element 0 through G in element 6.
    localparam logic [6:0][3:0] SEGMENT_ADDRESS = {
        4'd10, 4'd8, 4'd12, 4'd0, 4'd2, 4'd4, 4'd6
    };

    typedef struct packed {
        logic [3:0] address;
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    t_frame_byte expected_bytes[$];
    logic        blank_short_year;

    // Builds the frame that one display update produces and queues its bytes in order.
    function automatic void queue_frame(input logic [13:0] year, input logic [6:0] hour,
                                        input logic [6:0] minute, input logic [6:0] second,
                                        input logic [4:0] lamps, input logic blank);
        logic [7:0][6:0] digit_seg;
        logic [6:0]      hundreds;
        logic [7:0]      frame [FRAME_BYTES];
        t_frame_byte     entry;
        int              s;
        int              d;
        int              k;

        digit_seg[0] = DIGIT_SEGMENTS[second % 10];
        digit_seg[1] = DIGIT_SEGMENTS[(second / 10) % 10];
        digit_seg[2] = DIGIT_SEGMENTS[minute % 10];
        digit_seg[3] = DIGIT_SEGMENTS[(minute / 10) % 10];
        digit_seg[4] = DIGIT_SEGMENTS[hour % 10];
        digit_seg[5] = DIGIT_SEGMENTS[(hour / 10) % 10];
        digit_seg[6] = DIGIT_SEGMENTS[year % 10];
        digit_seg[7] = DIGIT_SEGMENTS[(year / 10) % 10];
        if (blank && year < YEAR_FULL) begin
            hundreds = '0;
        end else begin
            hundreds = DIGIT_SEGMENTS[(year / 100) % 10];
        end

        // Transpose: each segment gets an even byte over the eight digits and an
        // odd byte that carries the hundreds digit.
        for (s = 0; s < 7; s++) begin
            for (d = 0; d < 8; d++) begin
                frame[SEGMENT_ADDRESS[s]][d] = digit_seg[d][s];
            end
            frame[SEGMENT_ADDRESS[s] + 4'd1] = {7'b0, hundreds[s]};
        end

        // Lamp order in the vector: minute, hour, ntp, enabled, network.
        frame[ADDR_MINUTE_LAMP][1]  = lamps[0];
        frame[ADDR_HOUR_LAMP][1]    = lamps[1];
        frame[ADDR_NTP_LAMP][1]     = lamps[2];
        frame[ADDR_ENABLED_LAMP][1] = lamps[3];
        frame[ADDR_NETWORK_LAMP][1] = lamps[4];

        for (k = 0; k < FRAME_BYTES; k++) begin
            entry.address = 4'(k);
            entry.data    = frame[k];
            entry.last    = (k == FRAME_BYTES - 1);
            expected_bytes.push_back(entry);
        end
    endfunction

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_updates       = 0;
        o_bytes_checked = 0;
        blank_short_year = 1'b0;
    end

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin : watch
        t_frame_byte want;
        if (!i_rst_n) begin
            blank_short_year = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                blank_short_year = i_cfg_suppress_leading;
            end

            // Compare a delivered byte before queuing a new request's bytes.
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("Unexpected frame byte: address %0d, byte 0x%02h, last %0b",
                           i_frame_address, i_frame_byte, i_frame_last);
                    o_fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    o_bytes_checked++;
                    if (i_frame_address !== want.address) begin
                        $error("frame_address mismatch: expected %0d, got %0d",
                               want.address, i_frame_address);
                        o_fail_count++;
                    end
                    if (i_frame_byte !== want.data) begin
                        $error("frame_byte mismatch at address %0d: expected 0x%02h, got 0x%02h",
                               want.address, want.data, i_frame_byte);
                        o_fail_count++;
                    end
                    if (i_frame_last !== want.last) begin
                        $error("frame_last mismatch at address %0d: expected %0b, got %0b",
                               want.address, want.last, i_frame_last);
                        o_fail_count++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                queue_frame(i_year_value, i_hour_value, i_minute_value, i_second_value,
                            {i_network_lamp, i_enabled_lamp, i_ntp_lamp, i_hour_lamp,
                             i_minute_lamp},
                            blank_short_year);
                o_updates++;
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

[tb/tb.sv]
// Testbench top for the clock frame builder: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
    import csfb_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [4:0]  lamps;  // minute, hour, ntp, enabled, network from bit 0
    } t_update;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [13:0] i_year_value = '0;
    logic [6:0]  i_hour_value = '0;
    logic [6:0]  i_minute_value = '0;
    logic [6:0]  i_second_value = '0;
    logic        i_minute_lamp = 1'b0;
    logic        i_hour_lamp = 1'b0;
    logic        i_ntp_lamp = 1'b0;
    logic        i_enabled_lamp = 1'b0;
    logic        i_network_lamp = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_frame_address;
    logic [7:0]  o_frame_byte;
    logic        o_frame_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_suppress_leading = 1'b0;

    int          fail_count;
    int          pending_bytes;
    int          updates_seen;
    int          bytes_checked;
    int          setting_writes = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rx_stall_left = 0;
    int unsigned rx_calm_left = 0;

    clock_seven_segment_frame_builder_core uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_year_value           (i_year_value),
        .i_hour_value           (i_hour_value),
        .i_minute_value         (i_minute_value),
        .i_second_value         (i_second_value),
        .i_minute_lamp          (i_minute_lamp),
        .i_hour_lamp            (i_hour_lamp),
        .i_ntp_lamp             (i_ntp_lamp),
        .i_enabled_lamp         (i_enabled_lamp),
        .i_network_lamp         (i_network_lamp),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_frame_address        (o_frame_address),
        .o_frame_byte           (o_frame_byte),
        .o_frame_last           (o_frame_last),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_suppress_leading (i_cfg_suppress_leading)
    );

    csfb_frame_checker frame_checker (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .i_in_ready             (o_in_ready),
        .i_year_value           (i_year_value),
        .i_hour_value           (i_hour_value),
        .i_minute_value         (i_minute_value),
        .i_second_value         (i_second_value),
        .i_minute_lamp          (i_minute_lamp),
        .i_hour_lamp            (i_hour_lamp),
        .i_ntp_lamp             (i_ntp_lamp),
        .i_enabled_lamp         (i_enabled_lamp),
        .i_network_lamp         (i_network_lamp),
        .i_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .i_frame_address        (o_frame_address),
        .i_frame_byte           (o_frame_byte),
        .i_frame_last           (o_frame_last),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_ready            (o_cfg_ready),
        .i_cfg_suppress_leading (i_cfg_suppress_leading),
        .o_fail_count           (fail_count),
        .o_pending              (pending_bytes),
        .o_updates              (updates_seen),
        .o_bytes_checked        (bytes_checked)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Consumer pacing: mostly ready, short and occasional long stalls, and calm stretches.
    always @(negedge i_clk) begin : rx_pacing
        int unsigned pick;
        if (rx_calm_left != 0) begin
            i_out_ready = 1'b1;
            rx_calm_left--;
        end else if (rx_stall_left != 0) begin
            i_out_ready = 1'b0;
            rx_stall_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                rx_calm_left = $urandom_range(40, 150);
                i_out_ready = 1'b1;
            end else if (pick < 20) begin
                rx_stall_left = $urandom_range(0, 2);
                i_out_ready = 1'b0;
            end else if (pick < 23) begin
                rx_stall_left = $urandom_range(10, 40);
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("No request moved for %0d cycles, %0d frame bytes outstanding",
                   STALL_LIMIT, pending_bytes);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_update make_update(input int unsigned year, input int unsigned hour,
                                            input int unsigned minute,
                                            input int unsigned second,
                                            input logic [4:0] lamps);
        t_update u;
        u.year   = 14'(year);
        u.hour   = 7'(hour);
        u.minute = 7'(minute);
        u.second = 7'(second);
        u.lamps  = lamps;
        return u;
    endfunction

    // Random update, weighted toward the year-1000 boundary and short years.
    function automatic t_update random_update();
        t_update     u;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            u.year = 14'($urandom_range(0, 9999));
        end else if (pick < 7) begin
            u.year = 14'($urandom_range(900, 1100));
        end else if (pick < 8) begin
            u.year = 14'($urandom_range(0, 120));
        end else begin
            u.year = 14'($urandom_range(0, 16383));
        end
        u.hour   = 7'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 127 : 99));
        u.minute = 7'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 127 : 99));
        u.second = 7'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 127 : 99));
        u.lamps  = 5'($urandom);
        return u;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Presents one update after an idle gap and holds it until it is taken.
    task automatic send_update(input t_update u, input int unsigned gap);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_year_value   = u.year;
        i_hour_value   = u.hour;
        i_minute_value = u.minute;
        i_second_value = u.second;
        i_minute_lamp  = u.lamps[0];
        i_hour_lamp    = u.lamps[1];
        i_ntp_lamp     = u.lamps[2];
        i_enabled_lamp = u.lamps[3];
        i_network_lamp = u.lamps[4];
        i_in_valid     = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every queued frame byte has been delivered.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending_bytes != 0) @(negedge i_clk);
    endtask

    task automatic write_suppress(input logic blank);
        i_cfg_suppress_leading = blank;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        setting_writes++;
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        int unsigned burst_left;

        burst_left = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames with the hundreds digit always shown.
        write_suppress(1'b0);
        send_update(make_update(0, 0, 0, 0, 5'b00000), 0);
        send_update(make_update(9999, 99, 99, 99, 5'b11111), 0);
        send_update(make_update(16383, 127, 127, 127, 5'b11111), 0);
        send_update(make_update(1234, 56, 78, 90, 5'b00001), 2);
        send_update(make_update(5678, 12, 34, 56, 5'b00010), 0);
        send_update(make_update(2026, 23, 59, 59, 5'b00100), 0);
        send_update(make_update(999, 9, 8, 7, 5'b01000), 1);
        send_update(make_update(1000, 10, 20, 30, 5'b10000), 0);
        send_update(make_update(99, 100, 115, 127, 5'b01010), 0);
        send_update(make_update(10000, 0, 1, 2, 5'b10101), 0);

        // Directed frames around the blanking boundary.
        wait_drained();
        write_suppress(1'b1);
        send_update(make_update(999, 11, 22, 33, 5'b11111), 0);
        send_update(make_update(1000, 44, 55, 66, 5'b00000), 0);
        send_update(make_update(0, 0, 0, 0, 5'b01110), 0);
        send_update(make_update(9, 1, 2, 3, 5'b10001), 3);
        send_update(make_update(99, 4, 5, 6, 5'b00000), 0);
        send_update(make_update(100, 7, 8, 9, 5'b11111), 0);
        send_update(make_update(16383, 127, 127, 127, 5'b11111), 0);
        send_update(make_update(12345, 99, 0, 99, 5'b00011), 0);
        send_update(make_update(1999, 19, 29, 39, 5'b11100), 0);

        // Random phases, alternating the blanking setting between drained points.
        for (phase = 0; phase < 4; phase++) begin
            wait_drained();
            write_suppress(phase[0]);
            for (n = 0; n < 38; n++) begin
                if (burst_left == 0 && $urandom_range(0, 19) == 0) begin
                    burst_left = $urandom_range(8, 16);
                end
                if ($urandom_range(0, 49) == 0) begin
                    wait_drained();
                end
                if (burst_left != 0) begin
                    burst_left--;
                    send_update(random_update(), 0);
                end else begin
                    send_update(random_update(), pick_gap());
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_bytes != 0) begin
            $error("%0d expected frame bytes never arrived", pending_bytes);
        end
        $display("Sent %0d display updates and checked %0d frame bytes across %0d writes",
                 updates_seen, bytes_checked, setting_writes);
        $display("of the blanking register, with random stalls on both channels.");
        if (fail_count == 0 && pending_bytes == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
